### src/rs3_pkg.sv
// rs3_pkg: shared constants and types for the rgb 3x3 sharpen stream
// line buffer geometry, configuration register indexes, control structs
// no dependencies
package rs3_pkg;

  // line buffer depth, largest supported image width
  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);
  // column counter also holds the width itself during the flush
  localparam int ColW     = $clog2(MaxWidth + 1);

  localparam int ChanW    = 8;
  localparam int NumChan  = 3;
  localparam int PixW     = ChanW * NumChan;
  localparam int LineW    = 2 * PixW;

  localparam int WidthW   = 11;
  localparam int HeightW  = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;
  localparam int CmpW     = (WidthW > ColW) ? WidthW : ColW;

  localparam logic [CfgIdxW-1:0] RegWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'd1;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightW-1:0] HeightReset = 16'd480;

  // which neighbours of the centre lie inside the image
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_mask_t;

  // per transaction control from the position tracker
  typedef struct packed {
    logic             go;
    logic             rd;
    logic             wr;
    logic [AddrW-1:0] addr;
    logic             emit;
    nbr_mask_t        nbr;
    logic             last;
  } item_ctl_t;

endpackage

### src/rs3_ram.sv
// rs3_ram: generic single write port, single read port memory
// read data registered and held while no read is enabled
// no dependencies
module rs3_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rs3_lane.sv
// rs3_lane: one colour channel of the sharpen kernel with clamp to 0..255
// five times centre minus the in-image edge neighbours
// depends on rs3_pkg
module rs3_lane (
  input  rs3_pkg::nbr_mask_t        nbr_i,
  input  logic [rs3_pkg::ChanW-1:0] ctr_i,
  input  logic [rs3_pkg::ChanW-1:0] up_i,
  input  logic [rs3_pkg::ChanW-1:0] dn_i,
  input  logic [rs3_pkg::ChanW-1:0] lf_i,
  input  logic [rs3_pkg::ChanW-1:0] rt_i,
  output logic [rs3_pkg::ChanW-1:0] res_o
);

  localparam int PosW = rs3_pkg::ChanW + 3;
  localparam int NegW = rs3_pkg::ChanW + 2;

  logic [PosW-1:0] pos;
  logic [NegW-1:0] neg;
  logic [PosW-1:0] diff;

  always_comb begin
    pos  = PosW'({ctr_i, 2'b00}) + PosW'(ctr_i);
    neg  = (nbr_i.up ? NegW'(up_i) : '0) + (nbr_i.dn ? NegW'(dn_i) : '0)
         + (nbr_i.lf ? NegW'(lf_i) : '0) + (nbr_i.rt ? NegW'(rt_i) : '0);
    diff = pos - PosW'(neg);
    if (PosW'(neg) > pos) begin
      res_o = '0;
    end else if (diff > PosW'({rs3_pkg::ChanW{1'b1}})) begin
      res_o = '1;
    end else begin
      res_o = diff[rs3_pkg::ChanW-1:0];
    end
  end

endmodule

### src/rs3_ctrl.sv
// rs3_ctrl: configuration registers and raster position tracking
// gives line buffer address, neighbour masks and output flags per transaction
// depends on rs3_pkg
module rs3_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rs3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rs3_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         accept_i,
  input  logic                         is_pad_i,
  output rs3_pkg::item_ctl_t           item_o
);

  localparam int ColW = rs3_pkg::ColW;
  localparam int HW   = rs3_pkg::HeightW;
  localparam int CmpW = rs3_pkg::CmpW;

  logic [rs3_pkg::WidthW-1:0] wcfg_q;
  logic [HW-1:0]              hcfg_q;
  logic [ColW-1:0]            col_q, col_d;
  logic [HW-1:0]              row_q, row_d;
  logic                       flush_q, flush_d;

  logic [CmpW-1:0] w_ext;
  logic [CmpW-1:0] w_cmp;
  logic [ColW-1:0] w;
  logic [HW-1:0]   h;
  logic [ColW-1:0] ci;
  logic [ColW-1:0] ci_nxt;
  logic [HW-1:0]   row_c;
  logic [HW-1:0]   rr;
  logic            ci_zero;

  always_comb begin
    w_ext = CmpW'(wcfg_q);
    w_cmp = (w_ext > CmpW'(rs3_pkg::MaxWidth)) ? CmpW'(rs3_pkg::MaxWidth) : w_ext;
    w     = (w_cmp == '0) ? ColW'(1) : ColW'(w_cmp);
    h     = (hcfg_q == '0) ? HW'(1) : hcfg_q;
  end

  always_comb begin
    ci      = (!flush_q && col_q >= w) ? '0 : col_q;
    row_c   = (row_q >= h) ? '0 : row_q;
    // during the flush the rows below are taken as the image height
    rr      = flush_q ? h : row_c;
    ci_zero = (ci == '0);
    ci_nxt  = ci + ColW'(1);

    item_o.go     = accept_i & (flush_q | ~is_pad_i);
    item_o.rd     = (ci < w);
    item_o.wr     = ~flush_q;
    item_o.addr   = ci[rs3_pkg::AddrW-1:0];
    item_o.emit   = ci_zero ? (rr >= HW'(2)) : (rr >= HW'(1));
    item_o.nbr.up = ci_zero ? (rr >= HW'(3)) : (rr >= HW'(2));
    item_o.nbr.dn = ~flush_q | ci_zero;
    item_o.nbr.lf = (ci >= ColW'(2)) | (ci_zero & (w >= ColW'(2)));
    item_o.nbr.rt = ~ci_zero & (ci < w);
    item_o.last   = flush_q & (ci >= w);
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (cfg_we_i) begin
      col_d   = '0;
      row_d   = '0;
      flush_d = 1'b0;
    end else if (item_o.go) begin
      if (!flush_q) begin
        if (ci_nxt >= w) begin
          col_d = '0;
          if (row_c + HW'(1) >= h) begin
            row_d   = '0;
            flush_d = 1'b1;
          end else begin
            row_d = row_c + HW'(1);
          end
        end else begin
          col_d = ci_nxt;
          row_d = row_c;
        end
      end else if (ci >= w) begin
        col_d   = '0;
        row_d   = '0;
        flush_d = 1'b0;
      end else begin
        col_d = ci_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcfg_q  <= rs3_pkg::WidthReset;
      hcfg_q  <= rs3_pkg::HeightReset;
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      flush_q <= flush_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rs3_pkg::RegWidth:  wcfg_q <= cfg_data_i[rs3_pkg::WidthW-1:0];
          rs3_pkg::RegHeight: hcfg_q <= cfg_data_i[HW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### src/rgb_sharpen_3x3_stream.sv
// rgb_sharpen_3x3_stream: streaming 3x3 sharpen over rgb pixels in raster order
// a transaction passes stage 1 and the stage 2 window into the result register
// throughput: one transaction per cycle unless stalled, set by the ram read port
// results trail the input by one row plus one pixel; width+1 pad ticks flush
// reset clears position, window and handshake state; line buffer is not cleared
// depends on rs3_pkg, rs3_ctrl, rs3_ram, rs3_lane
module rgb_sharpen_3x3_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rs3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rs3_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   red_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   blue_in_i,
  input  logic                         is_pad_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   red_out_o,
  output logic [7:0]                   green_out_o,
  output logic [7:0]                   blue_out_o,
  output logic                         last_pixel_o
);

  localparam int PixW  = rs3_pkg::PixW;
  localparam int ChanW = rs3_pkg::ChanW;
  localparam int LineW = rs3_pkg::LineW;

  logic out_ready, s2_ready, s1_ready, accept;
  rs3_pkg::item_ctl_t item;

  // stage 1: line buffer read in flight
  logic               s1_v_q;
  rs3_pkg::item_ctl_t s1_ctl_q;
  logic [PixW-1:0]    s1_cur_q;
  logic               byp_q;
  logic [LineW-1:0]   byp_data_q;

  // stage 2: window holds this transaction's neighbourhood
  logic               s2_v_q;
  logic               s2_emit_q;
  logic               s2_last_q;
  rs3_pkg::nbr_mask_t s2_nbr_q;

  logic [PixW-1:0] win_top1_q, win_top2_q;
  logic [PixW-1:0] win_mid0_q, win_mid1_q, win_mid2_q;
  logic [PixW-1:0] win_bot1_q, win_bot2_q;

  logic             out_v_q;
  logic [PixW-1:0]  out_pix_q;
  logic             out_last_q;

  logic [LineW-1:0] rdata;
  logic [LineW-1:0] line_sel;
  logic [PixW-1:0]  a_eff, m_eff;
  logic             wr_now;
  logic [LineW-1:0] wdata;
  logic [PixW-1:0]  res_pix;

  assign out_ready  = ~out_v_q | ~out_stall_i;
  assign s2_ready   = ~s2_v_q | out_ready;
  assign s1_ready   = ~s1_v_q | s2_ready;
  assign accept     = in_valid_i & s1_ready;
  assign in_stall_o = ~s1_ready;

  rs3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .is_pad_i   (is_pad_i),
    .item_o     (item)
  );

  // each entry keeps {row above, middle row} for one column
  rs3_ram #(
    .Width (LineW),
    .Depth (rs3_pkg::MaxWidth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr_now),
    .waddr_i (s1_ctl_q.addr),
    .wdata_i (wdata),
    .re_i    (item.go & item.rd),
    .raddr_i (item.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    line_sel = byp_q ? byp_data_q : rdata;
    a_eff    = s1_ctl_q.rd ? line_sel[LineW-1:PixW] : '0;
    m_eff    = s1_ctl_q.rd ? line_sel[PixW-1:0] : '0;
    wr_now   = s1_v_q & s1_ctl_q.wr & s2_ready;
    wdata    = {m_eff, s1_cur_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= item.go;
    end
  end

  // one-column width rereads the entry the previous transaction is writing
  always_ff @(posedge clk_i) begin
    if (s1_ready && item.go) begin
      s1_ctl_q   <= item;
      s1_cur_q   <= item.wr ? {red_in_i, green_in_i, blue_in_i} : '0;
      byp_q      <= wr_now & (s1_ctl_q.addr == item.addr);
      byp_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q     <= 1'b0;
      win_top1_q <= '0;
      win_top2_q <= '0;
      win_mid0_q <= '0;
      win_mid1_q <= '0;
      win_mid2_q <= '0;
      win_bot1_q <= '0;
      win_bot2_q <= '0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        win_top1_q <= win_top2_q;
        win_top2_q <= a_eff;
        win_mid0_q <= win_mid1_q;
        win_mid1_q <= win_mid2_q;
        win_mid2_q <= m_eff;
        win_bot1_q <= win_bot2_q;
        win_bot2_q <= s1_cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_emit_q <= s1_ctl_q.emit;
      s2_last_q <= s1_ctl_q.last;
      s2_nbr_q  <= s1_ctl_q.nbr;
    end
  end

  for (genvar gi = 0; gi < rs3_pkg::NumChan; gi++) begin : g_lane
    rs3_lane u_lane (
      .nbr_i (s2_nbr_q),
      .ctr_i (win_mid1_q[ChanW*gi +: ChanW]),
      .up_i  (win_top1_q[ChanW*gi +: ChanW]),
      .dn_i  (win_bot1_q[ChanW*gi +: ChanW]),
      .lf_i  (win_mid0_q[ChanW*gi +: ChanW]),
      .rt_i  (win_mid2_q[ChanW*gi +: ChanW]),
      .res_o (res_pix[ChanW*gi +: ChanW])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_v_q & s2_emit_q;
    end
  end

  // lanes merged back into one pixel
  always_ff @(posedge clk_i) begin
    if (out_ready && s2_v_q) begin
      out_pix_q  <= res_pix;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign red_out_o    = out_pix_q[3*ChanW-1:2*ChanW];
  assign green_out_o  = out_pix_q[2*ChanW-1:ChanW];
  assign blue_out_o   = out_pix_q[ChanW-1:0];
  assign last_pixel_o = out_last_q;

endmodule

### sim/tb_top.sv
// tb_top: self-checking bench for rgb_sharpen_3x3_stream, directed table then random images
// in-bench predictor of the 3x3 sharpen, bursty sender, patterned receiver stalls
// depends on rs3_pkg and the rgb_sharpen_3x3_stream rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CfgSettleCycles = 8;
  localparam int DrainTail       = 16;
  localparam int CycleLimit      = 400000;
  localparam int RandomItems     = 400;
  localparam int ShowMax         = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } px_out_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_e;
  typedef enum logic {ROW_PIXEL, ROW_REG} row_e;
  typedef enum logic [1:0] {STALL_NEVER, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_e;

  typedef struct packed {
    row_e                         kind;
    logic [23:0]                  rgb;
    logic                         pad;
    chk_e                         chk;
    px_out_t                      want;
    logic [rs3_pkg::CfgIdxW-1:0]  idx;
    logic [rs3_pkg::CfgDataW-1:0] data;
  } plan_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [rs3_pkg::CfgIdxW-1:0]  cfg_idx = rs3_pkg::RegWidth;
  logic [rs3_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   red_in = '0;
  logic [7:0]                   green_in = '0;
  logic [7:0]                   blue_in = '0;
  logic                         is_pad = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   red_out;
  logic [7:0]                   green_out;
  logic [7:0]                   blue_out;
  logic                         last_pixel;

  // predictor state
  logic [23:0]                  up_line [rs3_pkg::MaxWidth];
  logic [23:0]                  mid_line [rs3_pkg::MaxWidth];
  logic [23:0]                  win [9];
  int                           col_pos;
  int                           row_pos;
  bit                           in_flush;
  logic [rs3_pkg::WidthW-1:0]   width_reg;
  logic [rs3_pkg::HeightW-1:0]  height_reg;

  px_out_t             pending_px [$];
  plan_row_t           plan [$];
  int                  errors = 0;
  int                  checked = 0;
  int                  taken = 0;
  int                  settings = 0;
  int                  burst_left = 0;
  int                  cycles = 0;
  int                  stall_left = 0;
  int                  stall_phase = 0;
  stall_mode_e         stall_mode = STALL_NEVER;

  rgb_sharpen_3x3_stream uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .is_pad_i     (is_pad),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_out_o    (red_out),
    .green_out_o  (green_out),
    .blue_out_o   (blue_out),
    .last_pixel_o (last_pixel)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, pending_px.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure, changes character at the end of each randomly sized stretch
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NEVER: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_phase % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    px_out_t seen;
    px_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {red_out, green_out, blue_out, last_pixel};
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= ShowMax) begin
          $display("unexpected result: r=%0d g=%0d b=%0d last=%0b",
                   seen.red, seen.green, seen.blue, seen.last);
        end
      end else begin
        want = pending_px.pop_front();
        checked++;
        if (seen.red !== want.red || seen.green !== want.green ||
            seen.blue !== want.blue || seen.last !== want.last) begin
          errors++;
          if (errors <= ShowMax) begin
            $display("result %0d: expected r=%0d g=%0d b=%0d last=%0b,",
                     checked, want.red, want.green, want.blue, want.last);
            $display("  got r=%0d g=%0d b=%0d last=%0b",
                     seen.red, seen.green, seen.blue, seen.last);
          end
        end
      end
    end
  end

  function automatic int eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > rs3_pkg::MaxWidth) return rs3_pkg::MaxWidth;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == '0) return 1;
    return int'(height_reg);
  endfunction

  function automatic logic [7:0] sharpen_lane(input int sh, input bit up_ok, input bit dn_ok,
                                              input bit lf_ok, input bit rt_ok);
    int acc;
    acc = 5 * int'(win[4][sh +: 8]);
    if (up_ok) acc -= int'(win[1][sh +: 8]);
    if (dn_ok) acc -= int'(win[7][sh +: 8]);
    if (lf_ok) acc -= int'(win[3][sh +: 8]);
    if (rt_ok) acc -= int'(win[5][sh +: 8]);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  task automatic predict_sharpen(input logic [23:0] rgb, input logic pad,
                                 output bit got, output px_out_t res);
    int w, h, ci, orow, ocol, k;
    logic [23:0] above, middle, cur;
    bit last, up_ok, dn_ok, lf_ok, rt_ok;
    w = eff_width();
    h = eff_height();
    got = 1'b0;
    res = '0;
    ci = col_pos;
    above = '0;
    middle = '0;
    cur = '0;
    last = 1'b0;
    orow = -1;
    ocol = -1;
    // a pad inside the image is simply dropped
    if (!in_flush && pad) return;
    if (!in_flush) begin
      if (ci >= w) ci = 0;
      if (row_pos >= h) row_pos = 0;
      cur = rgb;
      above = up_line[ci];
      middle = mid_line[ci];
      up_line[ci] = middle;
      mid_line[ci] = cur;
    end else if (ci < w) begin
      above = up_line[ci];
      middle = mid_line[ci];
    end
    for (k = 0; k < 3; k++) begin
      win[3*k] = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = above;
    win[5] = middle;
    win[8] = cur;
    if (!in_flush) begin
      if (ci >= 1) begin
        orow = row_pos - 1;
        ocol = ci - 1;
      end else begin
        orow = row_pos - 2;
        ocol = w - 1;
      end
      ci++;
      if (ci >= w) begin
        ci = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          in_flush = 1'b1;
        end
      end
      col_pos = ci;
    end else begin
      if (ci >= 1) begin
        orow = h - 1;
        ocol = ci - 1;
      end else begin
        orow = h - 2;
        ocol = w - 1;
      end
      if (ci >= w) begin
        last = 1'b1;
        col_pos = 0;
        row_pos = 0;
        in_flush = 1'b0;
      end else begin
        col_pos = ci + 1;
      end
    end
    if (orow < 0 || ocol < 0) return;
    up_ok = (orow > 0);
    dn_ok = (orow < h - 1);
    lf_ok = (ocol > 0);
    rt_ok = (ocol < w - 1);
    res.red = sharpen_lane(16, up_ok, dn_ok, lf_ok, rt_ok);
    res.green = sharpen_lane(8, up_ok, dn_ok, lf_ok, rt_ok);
    res.blue = sharpen_lane(0, up_ok, dn_ok, lf_ok, rt_ok);
    res.last = last;
    got = 1'b1;
  endtask

  // sender holds off until every owed result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_px.size() != 0);
  endtask

  task automatic cfg_write(input logic [rs3_pkg::CfgIdxW-1:0] idx,
                           input logic [rs3_pkg::CfgDataW-1:0] data);
    drain_results();
    // the last transaction may still be inside the pipe without owing a result
    repeat (CfgSettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rs3_pkg::RegWidth) width_reg = data[rs3_pkg::WidthW-1:0];
    else height_reg = data[rs3_pkg::HeightW-1:0];
    col_pos = 0;
    row_pos = 0;
    in_flush = 1'b0;
    settings++;
  endtask

  task automatic send_pixel(input logic [23:0] rgb, input logic pad, input chk_e chk,
                            input px_out_t want);
    int gap;
    bit got;
    px_out_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    {red_in, green_in, blue_in} <= rgb;
    is_pad <= pad;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!(pad && !in_flush)) taken++;
    predict_sharpen(rgb, pad, got, res);
    case (chk)
      CHK_MODEL: if (got) pending_px.push_back(res);
      CHK_TYPED: pending_px.push_back(want);
      default: ;
    endcase
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] rand_rgb();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  task automatic send_image(input int npix, input int nflush);
    int i;
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(0, 19) == 0) send_pixel(rand_rgb(), 1'b1, CHK_MODEL, '0);
      if ($urandom_range(0, 199) == 0) drain_results();
      send_pixel(rand_rgb(), 1'b0, CHK_MODEL, '0);
    end
    // flush ticks, some carrying pixel data that must be dropped
    for (i = 0; i < nflush; i++) begin
      send_pixel(rand_rgb(), ($urandom_range(0, 5) != 0), CHK_MODEL, '0);
    end
  endtask

  // typed rows are the final pixel of a one-pixel image, so last is always set
  function automatic plan_row_t pix_row(input logic [23:0] rgb, input logic pad,
                                        input chk_e chk, input logic [23:0] want);
    plan_row_t t;
    t = '0;
    t.kind = ROW_PIXEL;
    t.rgb = rgb;
    t.pad = pad;
    t.chk = chk;
    t.want = {want, 1'b1};
    return t;
  endfunction

  function automatic plan_row_t reg_row(input logic [rs3_pkg::CfgIdxW-1:0] idx,
                                        input logic [rs3_pkg::CfgDataW-1:0] data);
    plan_row_t t;
    t = '0;
    t.kind = ROW_REG;
    t.chk = CHK_NONE;
    t.idx = idx;
    t.data = data;
    return t;
  endfunction

  initial begin
    int start, w, h, pick;
    bit cut;
    foreach (up_line[i]) begin
      up_line[i] = '0;
      mid_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    in_flush = 1'b0;
    width_reg = rs3_pkg::WidthReset;
    height_reg = rs3_pkg::HeightReset;

    // straight out of reset the frame is 640 x 480, row 0 owes nothing
    plan.push_back(pix_row(24'h123456, 1'b0, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'hedcba9, 1'b0, CHK_NONE, 24'h0));
    // zero in both registers acts as 1 x 1: result is five times the pixel, clamped
    plan.push_back(reg_row(rs3_pkg::RegWidth, 16'd0));
    plan.push_back(reg_row(rs3_pkg::RegHeight, 16'd0));
    plan.push_back(pix_row(24'ha5a5a5, 1'b1, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'h333234, 1'b0, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b1, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b1, CHK_TYPED, 24'hfffaff));
    plan.push_back(pix_row(24'h000000, 1'b0, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'hff0011, 1'b0, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'h5a5a5a, 1'b1, CHK_TYPED, 24'h000000));
    plan.push_back(pix_row(24'h01020f, 1'b0, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'hffffff, 1'b1, CHK_NONE, 24'h0));
    plan.push_back(pix_row(24'hffffff, 1'b1, CHK_TYPED, 24'h050a4b));
    // 3 x 3 with full-scale steps, every border case of the mask
    plan.push_back(reg_row(rs3_pkg::RegWidth, 16'd3));
    plan.push_back(reg_row(rs3_pkg::RegHeight, 16'd3));
    plan.push_back(pix_row(24'hff0000, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h00ff00, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h0000ff, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h00ffff, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'hffffff, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h808080, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h7f7f7f, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h010101, 1'b0, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b1, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b1, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b1, CHK_MODEL, 24'h0));
    plan.push_back(pix_row(24'h000000, 1'b1, CHK_MODEL, 24'h0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) cfg_write(plan[i].idx, plan[i].data);
      else send_pixel(plan[i].rgb, plan[i].pad, plan[i].chk, plan[i].want);
    end

    // tallest frame, abandoned after a couple of rows
    cfg_write(rs3_pkg::RegWidth, 16'd5);
    cfg_write(rs3_pkg::RegHeight, '1);
    send_image(12, 0);

    start = taken;
    cut = 1'b1;
    while (taken - start < RandomItems) begin
      if (cut || $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 2);
        if (pick != 2) begin
          case ($urandom_range(0, 19))
            0: w = 0;
            1: w = 2;
            2, 3: w = $urandom_range(9, 40);
            default: w = $urandom_range(1, 8);
          endcase
          cfg_write(rs3_pkg::RegWidth, rs3_pkg::CfgDataW'(w));
        end
        if (pick != 1) begin
          case ($urandom_range(0, 9))
            0: h = 0;
            1: h = $urandom_range(6, 8);
            default: h = $urandom_range(1, 5);
          endcase
          cfg_write(rs3_pkg::RegHeight, rs3_pkg::CfgDataW'(h));
        end
      end
      if ($urandom_range(0, 9) == 0) drain_results();
      w = eff_width();
      h = eff_height();
      // a register write in mid-frame restarts the stream
      cut = ($urandom_range(0, 6) == 0);
      if (cut) send_image($urandom_range(0, w * h - 1), 0);
      else send_image(w * h, w + 1);
    end

    drain_results();
    repeat (DrainTail) @(posedge clk);
    if (pending_px.size() != 0) errors++;
    $display("covered %0d register writes and %0d transactions in, %0d results compared",
             settings, taken, checked);
    $display("frames from 1x1 up to 40 wide, a tallest frame cut short, stray pads, data in flush");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
